// ===== hw/rtl/pkst_pkg.sv =====
package pkst_pkg;

  localparam int CmdW       = 2;
  localparam int KnobIdxW   = 2;
  localparam int ValueW     = 12;
  localparam int ThresholdW = 12;
  localparam int PageOutW   = 2;
  localparam int ScaledW    = 10;
  localparam int ScaleShift = 2;
  localparam int PresetW    = 3;

  localparam logic [PresetW-1:0] PresetMask = 3'h7;
  localparam logic [ThresholdW-1:0] ThresholdReset = 12'd32;

  typedef enum logic [CmdW-1:0] {
    CmdSample = 2'd0,
    CmdPage   = 2'd1,
    CmdArp    = 2'd2,
    CmdPreset = 2'd3
  } cmd_t;

endpackage

// ===== hw/rtl/pkst_if.sv =====
interface pkst_in_if;
  logic                               valid;
  logic                               ready;
  logic [pkst_pkg::CmdW-1:0]          command;
  logic [pkst_pkg::KnobIdxW-1:0]      knob_index;
  logic [pkst_pkg::ValueW-1:0]        knob_value;

  modport source (output valid, output command, output knob_index, output knob_value,
                  input ready);
  modport sink   (input valid, input command, input knob_index, input knob_value,
                  output ready);
endinterface

interface pkst_out_if;
  logic                               valid;
  logic                               ready;
  logic [pkst_pkg::PageOutW-1:0]      page_number;
  logic                               knob_active;
  logic [pkst_pkg::ScaledW-1:0]       scaled_value;
  logic                               arp_enabled;
  logic [pkst_pkg::PresetW-1:0]       preset_number;

  modport source (output valid, output page_number, output knob_active,
                  output scaled_value, output arp_enabled, output preset_number,
                  input ready);
  modport sink   (input valid, input page_number, input knob_active,
                  input scaled_value, input arp_enabled, input preset_number,
                  output ready);
endinterface

// ===== hw/rtl/pkst_ram.sv =====
module pkst_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/paged_knob_soft_takeover_core.sv =====
// an accepted item is registered in stage 1, then in the result register
// throughput: one item per cycle unless res_ch stalls; the stored-value
// ram read is issued at accept and a same-address write from the previous
// item is forwarded
// reset (rst, synchronous): page, arp and preset cleared, all knobs active,
// threshold back to 32, stored values read as zero through per-entry written bits
module paged_knob_soft_takeover_core #(
  parameter int KNOBS       = 4,
  parameter int PAGES       = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                threshold_we,
  input  logic [pkst_pkg::ThresholdW-1:0]     threshold_data,
  pkst_in_if.sink                             cmd_ch,
  pkst_out_if.source                          res_ch
);

  localparam int KW    = (KNOBS > 1) ? $clog2(KNOBS) : 1;
  localparam int PW    = $clog2(PAGES);
  localparam int DEPTH = PAGES * KNOBS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (SAMPLE_BITS < pkst_pkg::ValueW) ? SAMPLE_BITS : pkst_pkg::ValueW;

  typedef struct packed {
    pkst_pkg::cmd_t            cmd;
    logic                      knob_ok;
    logic [KW-1:0]             kidx;
    logic [SW-1:0]             value;
    logic [AW-1:0]             addr;
    logic [PW-1:0]             page;
    logic                      arp;
    logic [pkst_pkg::PresetW-1:0] preset;
  } s1_t;

  logic [pkst_pkg::ThresholdW-1:0] threshold;
  logic [PW-1:0]                   page;
  logic [PW-1:0]                   page_next;
  logic                            arp;
  logic                            arp_next;
  logic [pkst_pkg::PresetW-1:0]    preset;
  logic [pkst_pkg::PresetW-1:0]    preset_next;
  logic [KNOBS-1:0]                marks;
  logic [DEPTH-1:0]                written;

  pkst_pkg::cmd_t                  in_cmd;
  logic [KW+1:0]                   kidx_wide;
  logic [KW-1:0]                   in_kidx;
  logic                            in_ok;
  logic [pkst_pkg::ValueW-1:0]     in_value_full;
  logic [PW:0]                     page_inc;
  logic [PW:0]                     page_lim;
  logic [AW-1:0]                   raddr;
  logic                            accept;

  s1_t                             s1;
  logic                            s1_valid;
  logic                            s1_adv;
  logic                            s1_fire;
  logic                            rd_written;
  logic                            byp_hit;
  logic [SW-1:0]                   byp_data;
  logic [SW-1:0]                   ram_rdata;
  logic [SW-1:0]                   stored;
  logic [SW-1:0]                   gap;
  logic                            take;
  logic                            act_now;
  logic                            s1_we;
  logic                            res_active;
  logic [SW-1:0]                   res_value;
  logic [pkst_pkg::ValueW-1:0]     res_value_wide;
  logic [PW+1:0]                   page_wide;

  // stage 0: decode and control state update at accept
  assign in_cmd        = pkst_pkg::cmd_t'(cmd_ch.command);
  assign kidx_wide     = (KW + 2)'(cmd_ch.knob_index);
  assign in_kidx       = kidx_wide[KW-1:0];
  assign in_ok         = int'(cmd_ch.knob_index) < KNOBS;
  assign in_value_full = cmd_ch.knob_value;
  assign page_inc      = (PW + 1)'(page) + (PW + 1)'(1);
  assign page_lim      = arp ? (PW + 1)'(PAGES) : (PW + 1)'(PAGES - 1);
  assign accept        = cmd_ch.valid && cmd_ch.ready;
  assign cmd_ch.ready  = !s1_valid || s1_adv;

  always_comb begin
    page_next   = page;
    arp_next    = arp;
    preset_next = preset;
    unique case (in_cmd)
      pkst_pkg::CmdSample: begin
      end
      pkst_pkg::CmdPage: begin
        page_next = (page_inc >= page_lim) ? '0 : page_inc[PW-1:0];
      end
      pkst_pkg::CmdArp: begin
        arp_next = !arp;
      end
      pkst_pkg::CmdPreset: begin
        preset_next = (preset + pkst_pkg::PresetW'(1)) & pkst_pkg::PresetMask;
      end
    endcase
  end

  assign raddr = AW'(int'(page_next) * KNOBS + int'(in_kidx));

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= pkst_pkg::ThresholdReset;
      page      <= '0;
      arp       <= 1'b0;
      preset    <= '0;
    end else begin
      if (threshold_we) begin
        threshold <= threshold_data;
      end
      if (accept) begin
        page   <= page_next;
        arp    <= arp_next;
        preset <= preset_next;
      end
    end
  end

  pkst_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (s1_fire && s1_we),
    .waddr (s1.addr),
    .wdata (s1.value),
    .re    (accept),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // stage 1: pickup decision against the stored value
  assign s1_adv  = !res_ch.valid || res_ch.ready;
  assign s1_fire = s1_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ch.ready) begin
      s1_valid <= cmd_ch.valid;
    end
    if (accept) begin
      s1.cmd     <= in_cmd;
      s1.knob_ok <= in_ok;
      s1.kidx    <= in_kidx;
      s1.value   <= in_value_full[SW-1:0];
      s1.addr    <= raddr;
      s1.page    <= page_next;
      s1.arp     <= arp_next;
      s1.preset  <= preset_next;
      rd_written <= written[raddr];
      byp_hit    <= s1_fire && s1_we && (s1.addr == raddr);
      byp_data   <= s1.value;
    end
  end

  assign stored  = byp_hit ? byp_data : (rd_written ? ram_rdata : '0);
  assign gap     = (s1.value >= stored) ? (s1.value - stored) : (stored - s1.value);
  assign take    = pkst_pkg::ThresholdW'(gap) < threshold;
  assign act_now = marks[s1.kidx] || take;
  assign s1_we   = (s1.cmd == pkst_pkg::CmdSample) && s1.knob_ok && act_now;

  always_comb begin
    res_active = 1'b0;
    res_value  = '0;
    if (s1.knob_ok) begin
      unique case (s1.cmd)
        pkst_pkg::CmdSample: begin
          res_active = act_now;
          res_value  = act_now ? s1.value : stored;
        end
        pkst_pkg::CmdPage: begin
          res_active = 1'b0;
          res_value  = stored;
        end
        pkst_pkg::CmdArp, pkst_pkg::CmdPreset: begin
          res_active = marks[s1.kidx];
          res_value  = stored;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marks   <= '1;
      written <= '0;
    end else if (s1_fire) begin
      if (s1.cmd == pkst_pkg::CmdPage) begin
        marks <= '0;
      end else if (s1_we) begin
        marks[s1.kidx]   <= 1'b1;
        written[s1.addr] <= 1'b1;
      end
    end
  end

  // result register
  assign page_wide      = (PW + 2)'(s1.page);
  assign res_value_wide = pkst_pkg::ValueW'(res_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_ch.valid <= 1'b0;
    end else if (s1_adv) begin
      res_ch.valid <= s1_valid;
    end
    if (s1_fire) begin
      res_ch.page_number   <= page_wide[pkst_pkg::PageOutW-1:0];
      res_ch.knob_active   <= res_active;
      res_ch.scaled_value  <= res_value_wide[pkst_pkg::ValueW-1:pkst_pkg::ScaleShift];
      res_ch.arp_enabled   <= s1.arp;
      res_ch.preset_number <= s1.preset;
    end
  end

  a_page_protects: assert property (@(posedge clk) disable iff (rst)
    s1_fire && (s1.cmd == pkst_pkg::CmdPage) |=> (marks == '0))
    else $error("page press did not protect all knobs");

  a_bad_knob_zero: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1.knob_ok |=> !res_ch.knob_active && (res_ch.scaled_value == '0))
    else $error("out of range knob reported nonzero fields");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1))
    else $error("stalled item in stage 1 changed");

  a_write_only_sample: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_we |-> (s1.cmd == pkst_pkg::CmdSample) && s1.knob_ok)
    else $error("store written by a non-sample item");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int KNOBS = 4;
  localparam int PAGES = 4;
  localparam int MAX_VALUE = (1 << pkst_pkg::ValueW) - 1;

  typedef struct packed {
    logic [pkst_pkg::PageOutW-1:0] page_number;
    logic                          knob_active;
    logic [pkst_pkg::ScaledW-1:0]  scaled_value;
    logic                          arp_enabled;
    logic [pkst_pkg::PresetW-1:0]  preset_number;
  } knob_report_t;

  class knob_pickup_board;
    logic [pkst_pkg::ValueW-1:0]  stored_values [KNOBS*PAGES];
    bit                           active_marks [KNOBS];
    int                           page;
    bit                           arp_on;
    logic [pkst_pkg::PresetW-1:0] preset;
    int                           threshold;
    knob_report_t                 expected_reports [$];
    int                           errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      foreach (stored_values[i]) stored_values[i] = '0;
      foreach (active_marks[i]) active_marks[i] = 1'b1;
      page = 0;
      arp_on = 1'b0;
      preset = '0;
      threshold = int'(pkst_pkg::ThresholdReset);
    endfunction

    function void set_threshold(logic [pkst_pkg::ThresholdW-1:0] t);
      threshold = int'(t);
    endfunction

    function logic [pkst_pkg::ValueW-1:0] stored_at(logic [pkst_pkg::KnobIdxW-1:0] k);
      return stored_values[page*KNOBS + k];
    endfunction

    function void note_item(pkst_pkg::cmd_t c, logic [pkst_pkg::KnobIdxW-1:0] k,
                            logic [pkst_pkg::ValueW-1:0] v);
      knob_report_t r;
      int slot;
      int gap;
      int limit;
      case (c)
        pkst_pkg::CmdSample: begin
          if (k < KNOBS) begin
            slot = page*KNOBS + k;
            gap = int'(v) - int'(stored_values[slot]);
            if (gap < 0) gap = -gap;
            if (gap < threshold) active_marks[k] = 1'b1;
            if (active_marks[k]) stored_values[slot] = v;
          end
        end
        pkst_pkg::CmdPage: begin
          limit = arp_on ? PAGES : PAGES - 1;
          page = page + 1;
          if (page >= limit) page = 0;
          foreach (active_marks[i]) active_marks[i] = 1'b0;
        end
        pkst_pkg::CmdArp: arp_on = !arp_on;
        default: preset = (preset + 1'b1) & pkst_pkg::PresetMask;
      endcase
      r.page_number = page[pkst_pkg::PageOutW-1:0];
      if (k < KNOBS) begin
        r.knob_active = active_marks[k];
        r.scaled_value = pkst_pkg::ScaledW'(stored_values[page*KNOBS + k] >>
                                            pkst_pkg::ScaleShift);
      end else begin
        r.knob_active = 1'b0;
        r.scaled_value = '0;
      end
      r.arp_enabled = arp_on;
      r.preset_number = preset;
      expected_reports.push_back(r);
    endfunction

    function void check_report(knob_report_t got);
      knob_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.page_number !== want.page_number) begin
        $display("%0t: page_number expected %0d actual %0d", $time,
                 want.page_number, got.page_number);
        errors++;
      end
      if (got.knob_active !== want.knob_active) begin
        $display("%0t: knob_active expected %0d actual %0d", $time,
                 want.knob_active, got.knob_active);
        errors++;
      end
      if (got.scaled_value !== want.scaled_value) begin
        $display("%0t: scaled_value expected %0d actual %0d", $time,
                 want.scaled_value, got.scaled_value);
        errors++;
      end
      if (got.arp_enabled !== want.arp_enabled) begin
        $display("%0t: arp_enabled expected %0d actual %0d", $time,
                 want.arp_enabled, got.arp_enabled);
        errors++;
      end
      if (got.preset_number !== want.preset_number) begin
        $display("%0t: preset_number expected %0d actual %0d", $time,
                 want.preset_number, got.preset_number);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            threshold_we;
  logic [pkst_pkg::ThresholdW-1:0] threshold_data;
  int                              send_idle_pct;
  int                              recv_idle_pct;

  knob_pickup_board board = new();

  pkst_in_if  cmd_if ();
  pkst_out_if res_if ();

  paged_knob_soft_takeover_core uut (
    .clk            (clk),
    .rst            (rst),
    .threshold_we   (threshold_we),
    .threshold_data (threshold_data),
    .cmd_ch         (cmd_if),
    .res_ch         (res_if)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      board.check_report({res_if.page_number, res_if.knob_active, res_if.scaled_value,
                          res_if.arp_enabled, res_if.preset_number});
    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input pkst_pkg::cmd_t c,
                           input logic [pkst_pkg::KnobIdxW-1:0] k,
                           input logic [pkst_pkg::ValueW-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.command <= c;
    cmd_if.knob_index <= k;
    cmd_if.knob_value <= v;
    do @(posedge clk); while (!cmd_if.ready);
    board.note_item(c, k, v);
  endtask

  task automatic write_threshold(input logic [pkst_pkg::ThresholdW-1:0] t);
    cmd_if.valid <= 1'b0;
    while (board.expected_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    threshold_we <= 1'b1;
    threshold_data <= t;
    @(posedge clk);
    threshold_we <= 1'b0;
    board.set_threshold(t);
  endtask

  task automatic send_random_item();
    pkst_pkg::cmd_t c;
    logic [pkst_pkg::KnobIdxW-1:0] k;
    logic [pkst_pkg::ValueW-1:0] v;
    int pick;
    int span;
    int near;
    pick = $urandom_range(99);
    if (pick < 70) c = pkst_pkg::CmdSample;
    else if (pick < 80) c = pkst_pkg::CmdPage;
    else if (pick < 90) c = pkst_pkg::CmdArp;
    else c = pkst_pkg::CmdPreset;
    k = pkst_pkg::KnobIdxW'($urandom_range(KNOBS - 1));
    pick = $urandom_range(99);
    if (pick < 45) begin
      // land around the stored value so pickup actually happens
      span = board.threshold + 2;
      near = int'(board.stored_at(k)) + int'($urandom_range(2*span)) - span;
      if (near < 0) near = 0;
      if (near > MAX_VALUE) near = MAX_VALUE;
      v = pkst_pkg::ValueW'(near);
    end else if (pick < 55) begin
      v = '0;
    end else if (pick < 65) begin
      v = pkst_pkg::ValueW'(MAX_VALUE);
    end else begin
      v = pkst_pkg::ValueW'($urandom);
    end
    send_item(c, k, v);
  endtask

  function automatic logic [pkst_pkg::ThresholdW-1:0] pick_threshold();
    case ($urandom_range(5))
      0: return '0;
      1: return pkst_pkg::ThresholdW'(1);
      2: return '1;
      3: return pkst_pkg::ThresholdReset;
      4: return pkst_pkg::ThresholdW'($urandom_range(255));
      default: return pkst_pkg::ThresholdW'($urandom_range((1 << pkst_pkg::ThresholdW) - 1));
    endcase
  endfunction

  initial begin
    rst <= 1'b1;
    threshold_we <= 1'b0;
    threshold_data <= '0;
    cmd_if.valid <= 1'b0;
    cmd_if.command <= pkst_pkg::CmdSample;
    cmd_if.knob_index <= '0;
    cmd_if.knob_value <= '0;
    send_idle_pct = 25;
    recv_idle_pct = 68;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    board.clear();

    // extremes with every knob active after reset
    send_item(pkst_pkg::CmdSample, 2'd0, 12'h000);
    send_item(pkst_pkg::CmdSample, 2'd3, 12'hfff);
    send_item(pkst_pkg::CmdSample, 2'd1, 12'haaa);
    send_item(pkst_pkg::CmdSample, 2'd2, 12'h555);
    send_item(pkst_pkg::CmdArp, 2'd1, 12'hfff);
    repeat (8) send_item(pkst_pkg::CmdPreset, 2'd2, 12'h000);
    // pickup on a fresh page
    send_item(pkst_pkg::CmdPage, 2'd3, 12'h123);
    send_item(pkst_pkg::CmdSample, 2'd1, 12'hfff);
    send_item(pkst_pkg::CmdSample, 2'd1, 12'd32);
    send_item(pkst_pkg::CmdSample, 2'd1, 12'd31);
    send_item(pkst_pkg::CmdSample, 2'd1, 12'd4000);
    // page wrap with arp off
    send_item(pkst_pkg::CmdArp, 2'd0, 12'h000);
    send_item(pkst_pkg::CmdPage, 2'd0, 12'h000);
    send_item(pkst_pkg::CmdPage, 2'd0, 12'h000);
    // zero threshold never picks up
    write_threshold('0);
    send_item(pkst_pkg::CmdSample, 2'd0, 12'h000);
    // page wrap with arp on
    send_item(pkst_pkg::CmdArp, 2'd2, 12'h000);
    repeat (4) send_item(pkst_pkg::CmdPage, 2'd1, 12'h000);
    // widest threshold: full-scale distance still protected
    write_threshold('1);
    send_item(pkst_pkg::CmdSample, 2'd0, 12'hfff);
    send_item(pkst_pkg::CmdSample, 2'd0, 12'hffe);
    write_threshold(pkst_pkg::ThresholdReset);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 68 : 0;
      recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 25 : 0;
      for (int n = 0; n < 230; n++) begin
        if (n % 58 == 0) write_threshold(pick_threshold());
        send_random_item();
      end
    end

    cmd_if.valid <= 1'b0;
    while (board.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("paged_knob_soft_takeover_core test passed");
    end else begin
      $display("paged_knob_soft_takeover_core test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("paged_knob_soft_takeover_core test failed");
    $finish;
  end

endmodule

// ===== paged_knob_soft_takeover_core.f =====
hw/rtl/pkst_pkg.sv
hw/rtl/pkst_if.sv
hw/rtl/pkst_ram.sv
hw/rtl/paged_knob_soft_takeover_core.sv
tb/testbench.sv
